// ===== hw/rtl/tcgw_pkg.sv =====
// Shared types and constants of the text console glyph writer.
package tcgw_pkg;

    // Glyph cell size in pixels.
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_WIDTH  = 8;

    // Field widths.
    localparam int BASE_W  = 24;
    localparam int DIM_W   = 11;
    localparam int COL_W   = 8;
    localparam int ROW_W   = 7;
    localparam int LINE_W  = 4;
    localparam int BITS_W  = 8;
    localparam int ADDR_W  = 25;
    localparam int COUNT_W = 23;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_DATA_W = 56;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS     = 3'd4;

    // Configuration reset values.
    localparam logic [BASE_W-1:0] RST_FRAME_BASE    = 24'd0;
    localparam logic [DIM_W-1:0]  RST_SCREEN_WIDTH  = 11'd800;
    localparam logic [DIM_W-1:0]  RST_SCREEN_HEIGHT = 11'd600;
    localparam logic [COL_W-1:0]  RST_COLUMNS       = 8'd100;
    localparam logic [ROW_W-1:0]  RST_TEXT_ROWS     = 7'd37;

    // Cursor reset position and the last scan line of a glyph.
    localparam logic [COL_W-1:0]  HOME_COL  = 8'd0;
    localparam logic [ROW_W-1:0]  HOME_ROW  = 7'd1;
    localparam logic [LINE_W-1:0] LAST_LINE = 4'(GLYPH_HEIGHT - 1);

    // Input item modes.
    localparam logic MODE_GLYPH   = 1'b0;
    localparam logic MODE_NEWLINE = 1'b1;

    // Result kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Configuration register set.
    typedef struct packed {
        logic [BASE_W-1:0] frame_base;
        logic [DIM_W-1:0]  screen_width;
        logic [DIM_W-1:0]  screen_height;
        logic [COL_W-1:0]  columns_per_line;
        logic [ROW_W-1:0]  text_rows;
    } cfg_t;

    // One decoded item waiting for address generation.
    typedef struct packed {
        logic              valid;
        logic              has_write;
        logic              has_clear;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [LINE_W-1:0] line;
        logic [BITS_W-1:0] bits;
    } job_t;

endpackage

// ===== hw/rtl/text_console_glyph_writer.sv =====
// Top level of the text console glyph writer: configuration and stream ports.
//
// Takes one input word per cycle while the job slot is free: a glyph row
// (mode 0) or a newline (mode 1). Each glyph row gives one masked write of
// eight white pixels; a word that overflows the last text row also gives a
// clear of the screen below the top glyph band, so that word offers the write
// and then the clear, and input stalls while the clear is pending. A newline
// gives no result or a single clear. A word is accepted into a job register
// and its first result then goes to an output register; the address path is
// one 11x11 multiply and a three-term add between them. Configuration takes
// effect on the cycle after the write and should be done while idle.
module text_console_glyph_writer (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] glyph_bits
    input  logic        s_tuser,   // [0] mode
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [24:0] pixel_addr, [32:25] pixel_mask,
                                   // [55:33] clear_count
    output logic        m_tuser,   // [0] op_kind
    output logic        m_tlast    // last_result
);
    import tcgw_pkg::*;

    cfg_t               cfg_reg;
    job_t               job;
    logic               job_take;
    logic [ADDR_W-1:0]  addr;
    logic [BITS_W-1:0]  mask;
    logic [COUNT_W-1:0] count;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base       <= RST_FRAME_BASE;
            cfg_reg.screen_width     <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height    <= RST_SCREEN_HEIGHT;
            cfg_reg.columns_per_line <= RST_COLUMNS;
            cfg_reg.text_rows        <= RST_TEXT_ROWS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_BASE:    cfg_reg.frame_base       <= cfg_data;
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width     <= cfg_data[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height    <= cfg_data[DIM_W-1:0];
                CFG_COLUMNS:       cfg_reg.columns_per_line <= cfg_data[COL_W-1:0];
                CFG_TEXT_ROWS:     cfg_reg.text_rows        <= cfg_data[ROW_W-1:0];
                default:           ;
            endcase
        end
    end

    // Cursor and job register.
    tcgw_cursor u_cursor (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_bits  (s_tdata),
        .job_take (job_take),
        .job      (job)
    );

    // Address generation and output register.
    tcgw_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (job),
        .job_take  (job_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_last  (m_tlast),
        .out_addr  (addr),
        .out_mask  (mask),
        .out_count (count)
    );

    assign m_tdata = {count, mask, addr};

endmodule

// ===== hw/rtl/tcgw_cursor.sv =====
// Cursor tracking and the job register that feeds address generation.
module tcgw_cursor (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tcgw_pkg::cfg_t           cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_mode,
    input  logic [7:0]               in_bits,
    input  logic                     job_take,
    output tcgw_pkg::job_t           job
);
    import tcgw_pkg::*;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [LINE_W-1:0] line_reg, line_next;
    job_t              job_reg, job_next;

    logic              accept;
    logic              advance_row;
    logic              row_overflow;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;

    // The job slot frees up when it is empty or handed on this cycle.
    assign in_ready = !job_reg.valid || job_take;
    assign accept   = in_valid && in_ready;

    assign col_inc      = {1'b0, col_reg} + 1'b1;
    assign row_inc      = {1'b0, row_reg} + 1'b1;
    assign row_overflow = row_inc >= {1'b0, cfg.text_rows};

    // Next cursor position for the accepted word.
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        line_next   = line_reg;
        advance_row = 1'b0;
        if (in_mode == MODE_NEWLINE)
        begin
            line_next   = '0;
            advance_row = 1'b1;
        end
        else if (line_reg == LAST_LINE)
        begin
            line_next = '0;
            if (col_inc >= {1'b0, cfg.columns_per_line})
            begin
                advance_row = 1'b1;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
        else
        begin
            line_next = line_reg + 1'b1;
        end
        if (advance_row)
        begin
            col_next = HOME_COL;
            row_next = row_overflow ? HOME_ROW : row_inc[ROW_W-1:0];
        end
    end

    // Job register contents: the position the word is drawn at.
    always_comb
    begin
        job_next = job_reg;
        if (accept)
        begin
            job_next.valid     = 1'b1;
            job_next.has_write = (in_mode == MODE_GLYPH);
            job_next.has_clear = advance_row && row_overflow;
            job_next.col       = col_reg;
            job_next.row       = row_reg;
            job_next.line      = line_reg;
            job_next.bits      = in_bits;
        end
        else if (job_take)
        begin
            job_next.valid = 1'b0;
        end
    end

    // Cursor state and job register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= HOME_COL;
            row_reg  <= HOME_ROW;
            line_reg <= '0;
            job_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                line_reg <= line_next;
            end
            job_reg <= job_next;
        end
    end

    assign job = job_reg;

endmodule

// ===== hw/rtl/tcgw_result.sv =====
// Address and clear-length generation with the output register.
module tcgw_result (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcgw_pkg::cfg_t                      cfg,
    input  tcgw_pkg::job_t                      job,
    output logic                                job_take,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_kind,
    output logic                                out_last,
    output logic [tcgw_pkg::ADDR_W-1:0]         out_addr,
    output logic [tcgw_pkg::BITS_W-1:0]         out_mask,
    output logic [tcgw_pkg::COUNT_W-1:0]        out_count
);
    import tcgw_pkg::*;

    localparam int LINE_IDX_W = ROW_W + LINE_W;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int BAND_W     = DIM_W + LINE_W;

    logic                valid_reg, valid_next;
    logic                pend_reg, pend_next;
    logic                kind_reg, kind_next;
    logic                last_reg, last_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [BITS_W-1:0]   mask_reg, mask_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic                out_free;
    logic [LINE_IDX_W-1:0] scan_line;
    logic [PROD_W-1:0]   line_offset;
    logic [ADDR_W-1:0]   write_addr;
    logic [BAND_W-1:0]   band;
    logic [PROD_W-1:0]   total;
    logic [COUNT_W-1:0]  clear_len;
    logic [ADDR_W-1:0]   clear_addr;

    // Write address: base + 8*col + width*(16*row + line).
    assign scan_line   = {job.row, job.line};
    assign line_offset = cfg.screen_width * PROD_W'(scan_line);
    assign write_addr  = ADDR_W'(cfg.frame_base)
                       + ADDR_W'({job.col, 3'b000})
                       + ADDR_W'(line_offset);

    // Clear region: everything below the top glyph band.
    assign band       = {cfg.screen_width, 4'b0000};
    assign total      = cfg.screen_width * cfg.screen_height;
    assign clear_len  = (total > PROD_W'(band)) ? COUNT_W'(total - PROD_W'(band)) : '0;
    assign clear_addr = ADDR_W'(cfg.frame_base) + ADDR_W'(band);

    // A pending clear goes out before the next job is taken.
    assign out_free = !valid_reg || out_ready;
    assign job_take = job.valid && out_free && !pend_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        addr_next  = addr_reg;
        mask_next  = mask_reg;
        count_next = count_reg;
        if (out_free)
        begin
            if (pend_reg || (job_take && !job.has_write && job.has_clear))
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                kind_next  = KIND_CLEAR;
                last_next  = 1'b1;
                addr_next  = clear_addr;
                mask_next  = '0;
                count_next = clear_len;
            end
            else if (job_take && job.has_write)
            begin
                valid_next = 1'b1;
                pend_next  = job.has_clear;
                kind_next  = KIND_WRITE;
                last_next  = !job.has_clear;
                addr_next  = write_addr;
                mask_next  = job.bits;
                count_next = '0;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control state of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        addr_reg  <= addr_next;
        mask_reg  <= mask_next;
        count_reg <= count_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_addr  = addr_reg;
    assign out_mask  = mask_reg;
    assign out_count = count_reg;

endmodule

// ===== hw/rtl/tcgw_checker.sv =====
// Port-level checks of the text console glyph writer and their binding.
module tcgw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import tcgw_pkg::*;

    // The output holds no word while reset is applied.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // A stalled output word stays offered.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    // A pixel write carries no clear length; a clear carries no mask and ends its item.
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_WRITE) ? (m_tdata[55:33] == '0)
                     : ((m_tdata[32:25] == '0) && m_tlast)))
        else $error("result fields do not match the result kind");

    // A write that is not the last of its item is followed at once by its clear.
    a_clear_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == KIND_WRITE) && !m_tlast
        |=> m_tvalid && (m_tuser == KIND_CLEAR))
        else $error("missing clear after a write without last");

endmodule

bind text_console_glyph_writer tcgw_checker u_tcgw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
